// ===== design/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the stable priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH   = 16;
  localparam int unsigned DEF_TAG_BITS      = 16;
  localparam int unsigned DEF_PRIORITY_BITS = 3;

  localparam int unsigned OP_BITS = 3;

  localparam logic [OP_BITS-1:0] OP_INSERT       = 3'd0;
  localparam logic [OP_BITS-1:0] OP_APPEND       = 3'd1;
  localparam logic [OP_BITS-1:0] OP_REMOVE_FRONT = 3'd2;
  localparam logic [OP_BITS-1:0] OP_REMOVE_AT    = 3'd3;
  localparam logic [OP_BITS-1:0] OP_READ_AT      = 3'd4;
  localparam logic [OP_BITS-1:0] OP_CLEAR        = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_SHIFT,
    S_INS_LAST,
    S_RM_HEAD,
    S_RM_SHIFT
  } spq_state_t;

endpackage

`default_nettype wire

// ===== design/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded queue of tagged entries ordered by priority, stable on insert.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its single result
// appears on the out_ ports for one cycle with out_valid high, and the receiver
// cannot stall it. Entries live in one memory with a registered read, and each
// operation walks that memory one entry per cycle. Append, clear, failed
// operations and insert into an empty queue answer straight from idle; read
// fetches its entry first; remove at position p moves every later entry one
// place toward the front; insert scans to the slot, then shifts the tail one
// entry a cycle. The result is registered from the last working state, and a
// new transaction can be taken in the cycle that it is shown.
`default_nettype none

module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
  parameter int unsigned TAG_BITS      = DEF_TAG_BITS,
  parameter int unsigned PRIORITY_BITS = DEF_PRIORITY_BITS,
  localparam int unsigned AW = $clog2(QUEUE_DEPTH),
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [OP_BITS-1:0]       in_opcode,
  input  wire logic [TAG_BITS-1:0]      in_entry_tag,
  input  wire logic [PRIORITY_BITS-1:0] in_entry_priority,
  input  wire logic [CW-1:0]            in_position,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [TAG_BITS-1:0]           out_result_tag,
  output logic [PRIORITY_BITS-1:0]      out_result_priority,
  output logic [CW-1:0]                 out_entry_count,
  output logic                          out_is_empty
);

  localparam int unsigned EW = TAG_BITS + PRIORITY_BITS;

  spq_state_t state_r, state_nxt;

  logic [CW-1:0]            count_r, count_nxt;
  logic [AW-1:0]            ptr_r, ptr_nxt;
  logic [OP_BITS-1:0]       op_r, op_nxt;
  logic [TAG_BITS-1:0]      tag_r, tag_nxt;
  logic [PRIORITY_BITS-1:0] pri_r, pri_nxt;
  logic [EW-1:0]            carry_r, carry_nxt;
  logic                     valid_r, valid_nxt;
  logic [1:0]               status_r, status_nxt;
  logic [TAG_BITS-1:0]      rtag_r, rtag_nxt;
  logic [PRIORITY_BITS-1:0] rpri_r, rpri_nxt;

  logic                     wr_en, rd_en;
  logic [AW-1:0]            wr_addr, rd_addr;
  logic [EW-1:0]            wr_data, rd_data;

  logic                     accept, full, empty, last, pos_bad;
  logic [CW-1:0]            pos_m1;
  logic [PRIORITY_BITS-1:0] rd_pri;

  assign accept  = start && (state_r == S_IDLE);
  assign full    = (count_r == CW'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign last    = ((CW'(ptr_r) + CW'(1)) == count_r);
  assign pos_bad = (in_position == '0) || (in_position > count_r);
  assign pos_m1  = in_position - CW'(1);
  assign rd_pri  = rd_data[PRIORITY_BITS-1:0];

  spq_ram #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(EW),
    .AW   (AW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_opcode)
            OP_INSERT: begin
              if (!full && !empty) state_nxt = S_INS_SCAN;
            end
            OP_REMOVE_FRONT: begin
              if (!empty) state_nxt = S_RM_HEAD;
            end
            OP_REMOVE_AT, OP_READ_AT: begin
              if (!empty && !pos_bad) state_nxt = S_RM_HEAD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS_SCAN: begin
        if (rd_pri < pri_r) begin
          state_nxt = last ? S_INS_LAST : S_INS_SHIFT;
        end else if (last) begin
          state_nxt = S_IDLE;
        end
      end
      S_INS_SHIFT: begin
        if (last) state_nxt = S_INS_LAST;
      end
      S_INS_LAST: state_nxt = S_IDLE;
      S_RM_HEAD: begin
        if (op_r == OP_READ_AT || last) state_nxt = S_IDLE;
        else                            state_nxt = S_RM_SHIFT;
      end
      S_RM_SHIFT: begin
        if (last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    op_nxt     = op_r;
    tag_nxt    = tag_r;
    pri_nxt    = pri_r;
    carry_nxt  = carry_r;
    valid_nxt  = 1'b0;
    status_nxt = status_r;
    rtag_nxt   = rtag_r;
    rpri_nxt   = rpri_r;
    wr_en      = 1'b0;
    wr_addr    = ptr_r;
    wr_data    = {tag_r, pri_r};
    rd_en      = 1'b0;
    rd_addr    = ptr_r + AW'(1);
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = in_opcode;
          tag_nxt    = in_entry_tag;
          pri_nxt    = in_entry_priority;
          status_nxt = ST_OK;
          rtag_nxt   = '0;
          rpri_nxt   = '0;
          ptr_nxt    = '0;
          valid_nxt  = 1'b1;
          unique case (in_opcode)
            OP_INSERT, OP_APPEND: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else if (in_opcode == OP_APPEND || empty) begin
                wr_en     = 1'b1;
                wr_addr   = count_r[AW-1:0];
                wr_data   = {in_entry_tag, in_entry_priority};
                count_nxt = count_r + CW'(1);
              end else begin
                valid_nxt = 1'b0;
                rd_en     = 1'b1;
                rd_addr   = '0;
              end
            end
            OP_REMOVE_FRONT: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                valid_nxt = 1'b0;
                rd_en     = 1'b1;
                rd_addr   = '0;
              end
            end
            OP_REMOVE_AT, OP_READ_AT: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else if (pos_bad) begin
                status_nxt = ST_BADPOS;
              end else begin
                valid_nxt = 1'b0;
                rd_en     = 1'b1;
                rd_addr   = pos_m1[AW-1:0];
                ptr_nxt   = pos_m1[AW-1:0];
              end
            end
            OP_CLEAR: count_nxt = '0;
            default: status_nxt = ST_OK;
          endcase
        end
      end
      S_INS_SCAN: begin
        if (rd_pri < pri_r) begin
          // The slot is found: drop the new entry here and carry the old one.
          wr_en     = 1'b1;
          carry_nxt = rd_data;
          ptr_nxt   = ptr_r + AW'(1);
          rd_en     = !last;
        end else if (last) begin
          wr_en     = 1'b1;
          wr_addr   = count_r[AW-1:0];
          count_nxt = count_r + CW'(1);
          valid_nxt = 1'b1;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
          rd_en   = 1'b1;
        end
      end
      S_INS_SHIFT: begin
        wr_en     = 1'b1;
        wr_data   = carry_r;
        carry_nxt = rd_data;
        ptr_nxt   = ptr_r + AW'(1);
        rd_en     = !last;
      end
      S_INS_LAST: begin
        wr_en     = 1'b1;
        wr_data   = carry_r;
        count_nxt = count_r + CW'(1);
        valid_nxt = 1'b1;
      end
      S_RM_HEAD: begin
        rtag_nxt = rd_data[EW-1:PRIORITY_BITS];
        rpri_nxt = rd_pri;
        if (op_r == OP_READ_AT) begin
          valid_nxt = 1'b1;
        end else if (last) begin
          count_nxt = count_r - CW'(1);
          valid_nxt = 1'b1;
        end else begin
          rd_en   = 1'b1;
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      S_RM_SHIFT: begin
        // Entry at ptr moves one place toward the front.
        wr_en   = 1'b1;
        wr_addr = ptr_r - AW'(1);
        wr_data = rd_data;
        if (last) begin
          count_nxt = count_r - CW'(1);
          valid_nxt = 1'b1;
        end else begin
          rd_en   = 1'b1;
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      default: valid_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    op_r     <= op_nxt;
    tag_r    <= tag_nxt;
    pri_r    <= pri_nxt;
    carry_r  <= carry_nxt;
    status_r <= status_nxt;
    rtag_r   <= rtag_nxt;
    rpri_r   <= rpri_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = valid_r;
  assign out_status          = status_r;
  assign out_result_tag      = rtag_r;
  assign out_result_priority = rpri_r;
  assign out_entry_count     = count_r;
  assign out_is_empty        = (count_r == '0);

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (state_r == S_IDLE))
    else $error("result shown while an operation is still walking the store");

  a_shift_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_SHIFT || state_r == S_INS_LAST) |-> !full)
    else $error("insert shift running on a full queue");

  a_rm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RM_SHIFT) |-> (ptr_r != '0))
    else $error("remove shift would write below the front");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || valid_r))
    else $error("accepted transaction neither working nor answered");

endmodule

`default_nettype wire

// ===== design/spq_ram.sv =====
// ----------------------------------------------------------------------------
// spq_ram
// Entry store: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 19,
  parameter int unsigned AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// tb_stable_priority_queue
// Self-checking testbench for the stable priority queue. Directed and random
// transactions are issued in bursts; a behavioral queue model predicts each
// result, and the monitor compares every result strobe with it in full.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_stable_priority_queue;
  import spq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int CWID  = 5;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] tag;
    logic [2:0]  prio;
    logic [4:0]  position;
  } queue_cmd_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [15:0]     tag;
    logic [2:0]      prio;
    logic [CWID-1:0] count;
    logic            empty;
  } queue_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_opcode = '0;
  logic [15:0] in_entry_tag = '0;
  logic [2:0] in_entry_priority = '0;
  logic [CWID-1:0] in_position = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [15:0] out_result_tag;
  logic [2:0] out_result_priority;
  logic [CWID-1:0] out_entry_count;
  logic out_is_empty;

  stable_priority_queue uut (
    .clk, .rst_n, .start, .busy, .in_opcode, .in_entry_tag, .in_entry_priority,
    .in_position, .out_valid, .out_status, .out_result_tag, .out_result_priority,
    .out_entry_count, .out_is_empty
  );

  always #4 clk = ~clk;

  queue_cmd_t  pending_cmds[$];
  queue_resp_t expected_resps[$];
  logic [15:0] model_tags[DEPTH];
  logic [2:0]  model_prios[DEPTH];
  int model_count = 0;
  int mismatches = 0;
  int cycles = 0;
  bit stim_done = 0;
  bit drain_hold = 0;
  int burst_left = 0;
  int gap_left = 0;
  int pushed_count = 0;  // model count as stimulus is generated

  // Applies one command to the model queue and returns the expected response.
  function automatic queue_resp_t model_apply(queue_cmd_t c);
    queue_resp_t r;
    int slot;
    int idx;
    r = '0;
    r.status = ST_OK;
    case (c.opcode)
      OP_INSERT, OP_APPEND: begin
        if (model_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot = model_count;
          if (c.opcode == OP_INSERT) begin
            slot = 0;
            while (slot < model_count && model_prios[slot] >= c.prio) slot++;
            for (int i = model_count; i > slot; i--) begin
              model_tags[i] = model_tags[i-1];
              model_prios[i] = model_prios[i-1];
            end
          end
          model_tags[slot] = c.tag;
          model_prios[slot] = c.prio;
          model_count++;
        end
      end
      OP_REMOVE_FRONT, OP_REMOVE_AT, OP_READ_AT: begin
        if (model_count == 0) begin
          r.status = ST_EMPTY;
        end else if (c.opcode != OP_REMOVE_FRONT &&
                     (c.position == 0 || c.position > model_count)) begin
          r.status = ST_BADPOS;
        end else begin
          idx = (c.opcode == OP_REMOVE_FRONT) ? 0 : c.position - 1;
          r.tag = model_tags[idx];
          r.prio = model_prios[idx];
          if (c.opcode != OP_READ_AT) begin
            for (int i = idx; i + 1 < model_count; i++) begin
              model_tags[i] = model_tags[i+1];
              model_prios[i] = model_prios[i+1];
            end
            model_count--;
          end
        end
      end
      OP_CLEAR: model_count = 0;
      default: ;
    endcase
    r.count = CWID'(model_count);
    r.empty = (model_count == 0);
    return r;
  endfunction

  // Tracks the count during generation so random positions stay relevant.
  function automatic void add_cmd(logic [2:0] op, logic [15:0] tg, logic [2:0] pr,
                                  logic [4:0] pos);
    queue_cmd_t c;
    c.opcode = op;
    c.tag = tg;
    c.prio = pr;
    c.position = pos;
    pending_cmds.push_back(c);
    case (op)
      OP_INSERT, OP_APPEND: if (pushed_count < DEPTH) pushed_count++;
      OP_REMOVE_FRONT: if (pushed_count > 0) pushed_count--;
      OP_REMOVE_AT:
        if (pushed_count > 0 && pos != 0 && pos <= pushed_count) pushed_count--;
      OP_CLEAR: pushed_count = 0;
      default: ;
    endcase
  endfunction

  // Driver: bursts with random gaps; the model runs when a command is accepted.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (start && !busy) begin
        expected_resps.push_back(model_apply({in_opcode, in_entry_tag,
                                              in_entry_priority, in_position}));
      end
      if (start && busy) begin
        // Keep the current transaction presented until it is taken.
      end else if (drain_hold && pending_cmds.size() > 0) begin
        start <= 1'b0;
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_cmds.size() > 0) begin
        queue_cmd_t c;
        c = pending_cmds.pop_front();
        start <= 1'b1;
        in_opcode <= c.opcode;
        in_entry_tag <= c.tag;
        in_entry_priority <= c.prio;
        in_position <= c.position;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobe must match the oldest expected response.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      queue_resp_t got;
      queue_resp_t exp_r;
      got = {out_status, out_result_tag, out_result_priority, out_entry_count,
             out_is_empty};
      if (expected_resps.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("Unexpected result %p", got);
      end else begin
        exp_r = expected_resps.pop_front();
        if (got !== exp_r) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("Mismatch: expected %p, got %p", exp_r, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int op;
    int fill;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty cases, full queue, stable ordering, bad positions.
    add_cmd(OP_REMOVE_FRONT, 0, 0, 1);
    add_cmd(OP_REMOVE_AT, 0, 0, 1);
    add_cmd(OP_READ_AT, 0, 0, 0);
    add_cmd(OP_CLEAR, 0, 0, 0);
    add_cmd(3'd6, 16'hFFFF, 7, 31);
    add_cmd(3'd7, 0, 0, 0);
    for (int i = 0; i < 16; i++) add_cmd(OP_INSERT, 16'(16'hA000 + i), 3'(i % 8), 0);
    add_cmd(OP_INSERT, 16'hFFFF, 7, 0);
    add_cmd(OP_APPEND, 0, 0, 0);
    add_cmd(OP_READ_AT, 0, 0, 0);
    add_cmd(OP_READ_AT, 0, 0, 17);
    add_cmd(OP_READ_AT, 0, 0, 31);
    add_cmd(OP_READ_AT, 0, 0, 16);
    add_cmd(OP_REMOVE_AT, 0, 0, 16);
    add_cmd(OP_REMOVE_AT, 0, 0, 1);
    add_cmd(OP_CLEAR, 0, 0, 0);
    add_cmd(OP_APPEND, 16'hFFFF, 7, 0);
    add_cmd(OP_REMOVE_AT, 0, 0, 1);
    add_cmd(OP_REMOVE_FRONT, 0, 0, 0);

    for (int n = 0; n < 1600; n++) begin
      // Drain once midway so the sender pauses until all results are back.
      if (n == 800) begin
        wait (pending_cmds.size() == 0);
        drain_hold = 1;
        wait (expected_resps.size() == 0 && !busy && !start);
        drain_hold = 0;
      end
      fill = $urandom_range(0, 99);
      if (fill < 40) op = (pushed_count > 12) ? $urandom_range(0, 4) : $urandom_range(0, 1);
      else if (fill < 95) op = $urandom_range(0, 4);
      else op = $urandom_range(5, 7);
      add_cmd(3'(op), 16'($urandom), 3'($urandom_range(0, 7)),
              5'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                             : $urandom_range(0, pushed_count + 1)));
      if (pending_cmds.size() > 64) wait (pending_cmds.size() < 32);
    end
    stim_done = 1;
    wait (pending_cmds.size() == 0);
    wait (expected_resps.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_resps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
